@@ hdl/swmad_pkg.sv @@
// Package for the sliding-window median deviation block.
// Holds default sizes, the cost width and the cell operation codes.
// No dependencies.
`default_nettype none

package swmad_pkg;

   // default sizes
   localparam int WINDOW_MAX_DEF  = 256;
   localparam int SAMPLE_BITS_DEF = 31;

   // fixed field widths
   localparam int LEN_W  = 9;
   localparam int COST_W = 39;

   // operation applied to every cell of the sorted row together
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL,
      CELL_ROT
   } cell_op_type;

endpackage

`default_nettype wire

@@ hdl/swmad_if.sv @@
// Valid/ready channel interfaces for sample, cost and window-length transfers.
// Depends on swmad_pkg for widths.
`default_nettype none

interface swmad_req_if
   import swmad_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swmad_rsp_if
   import swmad_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] cost;

   modport source (output valid, output cost, input ready);
   modport sink   (input valid, input cost, output ready);
endinterface

interface swmad_csr_if
   import swmad_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] window_len;

   modport source (output valid, output window_len, input ready);
   modport sink   (input valid, input window_len, output ready);
endinterface

`default_nettype wire

@@ hdl/swmad_cell.sv @@
// One cell of the sorted row: holds one sample at a fixed sorted position.
// Depends on swmad_pkg (cell_op_type).
`default_nettype none

module swmad_cell
   import swmad_pkg::*;
#(
   parameter int INDEX       = 0,
   parameter int CNT_W       = 9,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire cell_op_type            op,
   input  wire logic [CNT_W-1:0]       count,
   input  wire logic [SAMPLE_BITS-1:0] key,
   input  wire logic [SAMPLE_BITS-1:0] left_value,
   input  wire logic                   left_gt,
   input  wire logic [SAMPLE_BITS-1:0] right_value,
   input  wire logic [SAMPLE_BITS-1:0] head_value,
   output logic      [SAMPLE_BITS-1:0] value,
   output logic                        gt
);

   localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(INDEX + 1);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;
   logic                   occupied;
   logic                   ge;

   assign value = value_ff;

   // empty cells act as +infinity
   assign occupied = count > POS;
   assign gt       = !occupied || (value_ff > key);
   assign ge       = occupied && (value_ff >= key);

   always_comb begin
      case (op)
         CELL_INS: begin
            // larger entries move one place up, key drops into the gap
            if (left_gt) begin
               value_in = left_value;
            end else if (gt) begin
               value_in = key;
            end else begin
               value_in = value_ff;
            end
         end
         CELL_DEL: begin
            // entries from the first copy of key upward move one place down
            value_in = ge ? right_value : value_ff;
         end
         CELL_ROT: begin
            // rotate occupied part of the row so each entry passes cell 0
            if (POS_NEXT < count) begin
               value_in = right_value;
            end else if (POS_NEXT == count) begin
               value_in = head_value;
            end else begin
               value_in = value_ff;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

@@ hdl/swmad_delay.sv @@
// Delay line memory of raw samples, one write and one registered read port.
// Read returns the entry before the same-cycle write. Depends on swmad_pkg.
`default_nettype none

module swmad_delay
   import swmad_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(WINDOW_MAX)-1:0] addr,
   input  wire logic [SAMPLE_BITS-1:0]        wr_data,
   output logic      [SAMPLE_BITS-1:0]        rd_data
);

   logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/sliding_window_median_cost_top.sv @@
// Top level of the sliding-window median cost block (sum of absolute deviations from the median).
// Depends on swmad_pkg, the channel interfaces, swmad_cell and swmad_delay.
//
//  channel | dir | payload            | transfer when
//  --------+-----+--------------------+-------------------------
//  req     | in  | sample             | req.valid & req.ready
//  rsp     | out | cost               | rsp.valid & rsp.ready
//  csr     | in  | window_len         | csr.valid & csr.ready
//
// While the window fills, an item is accepted and inserted into the sorted row of
// cells; the item that fills it also has the row rotated and the cost loaded.
// Once full, an item is accepted, the oldest sample is deleted, the new one is
// inserted, then the row rotates once past cell 0 to gather the median and half
// sums, then the cost is loaded into the output register. A new sample is taken
// only while the block is idle, once the previous one is through.
// Synchronous reset clears the window; delay memory and cells are not cleared.
// A stalled rsp holds the block in its final state until the earlier cost is taken.
`default_nettype none

module sliding_window_median_cost_top
   import swmad_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   swmad_req_if.sink   req,
   swmad_rsp_if.source rsp,
   swmad_csr_if.sink   csr
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEL,
      ST_INS,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [PTR_W-1:0]       wptr_ff;
   logic [CNT_W-1:0]       scan_ff;
   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0] med_ff;
   logic [COST_W-1:0]      lower_ff;
   logic [COST_W-1:0]      upper_ff;
   logic                   rsp_valid_ff;
   logic [COST_W-1:0]      rsp_cost_ff;

   logic                   req_xfer;
   logic                   csr_xfer;
   logic                   rsp_load;
   logic [CNT_W-1:0]       win;
   logic [CMP_W-1:0]       len_ext;
   logic [PTR_W-1:0]       wptr_in;
   logic [CNT_W:0]         lower_cnt;
   logic [CNT_W:0]         scan_ext;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic [SAMPLE_BITS-1:0] key;
   logic [COST_W-1:0]      head_ext;
   logic [COST_W-1:0]      cost_in;
   cell_op_type            cell_op;

   logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
   logic                   cell_gt    [WINDOW_MAX];

   // handshakes; a register write takes priority over a sample
   assign req.ready = (state_ff == ST_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign csr_xfer  = csr.valid && csr.ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.cost  = rsp_cost_ff;

   // effective window: zero reads as one, clamp to row size
   assign len_ext = CMP_W'(len_ff);
   always_comb begin
      if (len_ext == '0) begin
         win = CNT_W'(1);
      end else if (len_ext > CMP_W'(WINDOW_MAX)) begin
         win = CNT_W'(WINDOW_MAX);
      end else begin
         win = CNT_W'(len_ext);
      end
   end

   // next delay slot, wrapping at the window
   assign wptr_in = (CNT_W'(wptr_ff) + CNT_W'(1) >= win) ? '0 : PTR_W'(wptr_ff + 1'b1);

   // delay line
   swmad_delay #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_delay (
      .clock   (clock),
      .wr_en   (req_xfer),
      .addr    (wptr_ff),
      .wr_data (req.sample),
      .rd_data (old_sample)
   );

   // cell row control
   always_comb begin
      case (state_ff)
         ST_DEL:  cell_op = CELL_DEL;
         ST_INS:  cell_op = CELL_INS;
         ST_SCAN: cell_op = CELL_ROT;
         default: cell_op = CELL_HOLD;
      endcase
   end
   assign key = (state_ff == ST_DEL) ? old_sample : x_ff;

   // sorted row
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] left_v;
      logic                   left_g;
      logic [SAMPLE_BITS-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_g = cell_gt[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_body
         assign right_v = cell_value[i+1];
      end

      swmad_cell #(
         .INDEX       (i),
         .CNT_W       (CNT_W),
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock       (clock),
         .op          (cell_op),
         .count       (count_ff),
         .key         (key),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   // scan bookkeeping and cost
   assign lower_cnt = ({1'b0, count_ff} + 1'b1) >> 1;
   assign scan_ext  = {1'b0, scan_ff};
   assign head_ext  = COST_W'(cell_value[0]);
   assign cost_in   = (count_ff[0] ? COST_W'(med_ff) : '0) - lower_ff + upper_ff;

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_W'(1);
         count_ff     <= '0;
         wptr_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (csr_xfer) begin
                  len_ff   <= csr.window_len;
                  count_ff <= '0;
                  wptr_ff  <= '0;
               end else if (req_xfer) begin
                  x_ff     <= req.sample;
                  wptr_ff  <= wptr_in;
                  state_ff <= (count_ff >= win) ? ST_DEL : ST_INS;
               end
            end
            ST_DEL: begin
               count_ff <= count_ff - 1'b1;
               state_ff <= ST_INS;
            end
            ST_INS: begin
               count_ff <= count_ff + 1'b1;
               scan_ff  <= '0;
               lower_ff <= '0;
               upper_ff <= '0;
               state_ff <= (count_ff + 1'b1 >= win) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
               // cell 0 holds the sorted entry at scan position
               if (scan_ext < lower_cnt) begin
                  lower_ff <= lower_ff + head_ext;
               end else begin
                  upper_ff <= upper_ff + head_ext;
               end
               if (scan_ext + 1'b1 == lower_cnt) begin
                  med_ff <= cell_value[0];
               end
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff + 1'b1 == count_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cost_ff  <= cost_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // window occupancy never exceeds the effective window
   assert property (@(posedge clock) disable iff (reset) count_ff <= win)
      else $error("window count above window length");

   // the rotation counter stays inside the occupied cells
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < count_ff))
      else $error("scan position outside window");

   // a loaded cost is offered in the next cycle
   assert property (@(posedge clock) disable iff (reset) rsp_load |=> rsp.valid)
      else $error("cost load lost");

   // a result only comes from a full window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (count_ff == win))
      else $error("result from partial window");

endmodule

`default_nettype wire
